/* src/ndkf_pkg.sv */
// ndkf_pkg: shared constants, types and functions for the name de-duplicator
// with keyword filter. Holds the FNV-1a constants, table sizing and status codes.
// No dependencies.
`timescale 1ns / 1ps

package ndkf_pkg;

    // FNV-1a 32-bit constants
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // seen table sizing
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // history of lowercased name bytes, newest in element 0
    localparam int HIST_LEN = 8;

    typedef logic [HIST_LEN-1:0][7:0] hist_t;
    typedef logic [1:0]               status_t;

    // result status codes
    localparam status_t ST_NEW  = 2'd0;
    localparam status_t ST_SEEN = 2'd1;
    localparam status_t ST_SKIP = 2'd2;

    // fold A..Z to lower case, everything else passes
    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // tail holds the last nine bytes, oldest in the top byte, newest in the low byte;
    // true when one of the keywords ends at the newest byte
    function automatic logic kw_match(input logic [8*(HIST_LEN+1)-1:0] tail);
        logic hit;
        hit = (tail[8*7-1:0] == "compass")
            || (tail[8*6-1:0] == "marker")
            || (tail[8*5-1:0] == "quest")
            || (tail[8*6-1:0] == "target")
            || (tail[8*8-1:0] == "location")
            || (tail[8*8-1:0] == "floating")
            || (tail[8*9-1:0] == "objective");
        return hit;
    endfunction

endpackage

/* src/name_dedup_keyword_filter.sv */
// name_dedup_keyword_filter: top level. Hashes names byte by byte, matches
// keywords, and keeps a seen table of hashes in an internal memory.
// Depends on ndkf_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall): one item is one name byte with
//   byte_valid and last_byte. byte_valid low with last_byte high ends an
//   empty name; byte_valid and last_byte both low is an idle item.
//   Output channel (out_valid / out_stall): one item per name end, carrying
//   status (new / seen / skipped), keyword_hit and name_hash.
//   Timing: an item that does not end a name is accepted without a stall.
//   A name end holds in_stall while the single memory read port scans the
//   stored hashes (up to 256) one per cycle; then the last read is compared,
//   the result is decided and moved to the output register. An empty table
//   is not read, a saturated table is not scanned and a match ends the scan
//   at that entry.
//   in_stall is high from a name end until its result is in the output
//   register. Bytes of the next name are accepted while that result waits.
//   A stalled receiver holds the result; a further name end then waits until
//   the output register frees.
//   Reset: the table reads as empty (fill count cleared), no clearing pass is
//   needed; the saturated flag, hash and keyword history return to start.
module name_dedup_keyword_filter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           name_byte,
    input  logic                 byte_valid,
    input  logic                 last_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ndkf_pkg::status_t    status,
    output logic                 keyword_hit,
    output logic [31:0]          name_hash
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]                     state_reg, state_next;
    logic [31:0]                    hash_reg, hash_next;
    ndkf_pkg::hist_t                recent_reg, recent_next;
    logic                           kw_reg, kw_next;
    logic                           sat_reg, sat_next;
    logic [ndkf_pkg::CNT_W-1:0]     fill_reg, fill_next;
    logic [ndkf_pkg::CNT_W-1:0]     idx_reg, idx_next;
    logic                           pend_reg, pend_next;
    logic [31:0]                    key_reg, key_next;
    logic                           name_kw_reg, name_kw_next;
    ndkf_pkg::status_t              res_status_reg, res_status_next;
    logic                           res_hit_reg, res_hit_next;
    logic                           out_valid_reg, out_valid_next;
    ndkf_pkg::status_t              out_status_reg, out_status_next;
    logic                           out_hit_reg, out_hit_next;
    logic [31:0]                    out_hash_reg, out_hash_next;

    logic [31:0] seen_mem [ndkf_pkg::TABLE_DEPTH];
    logic [31:0] rd_data_reg;

    logic        in_fire;
    logic [7:0]  lc;
    logic [31:0] hash_upd;
    logic        kw_now;
    logic [31:0] byte_hash;
    logic        byte_kw;
    logic [31:0] final_hash;
    logic        rd_en;
    logic        wr_en;
    logic        found;
    logic        out_load;

    assign in_stall    = (state_reg != S_IDLE);
    assign in_fire     = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign keyword_hit = out_hit_reg;
    assign name_hash   = out_hash_reg;

    // byte datapath: FNV-1a step on the raw byte, keyword check on the folded byte
    assign lc         = ndkf_pkg::fold_lower(name_byte);
    assign hash_upd   = (hash_reg ^ {24'd0, name_byte}) * ndkf_pkg::FNV_PRIME;
    assign kw_now     = ndkf_pkg::kw_match({recent_reg, lc});
    assign byte_hash  = byte_valid ? hash_upd : hash_reg;
    assign byte_kw    = kw_reg | (byte_valid & kw_now);
    assign final_hash = (byte_hash == 32'd0) ? 32'd1 : byte_hash;

    // scan control
    assign rd_en    = (state_reg == S_SCAN) && (idx_reg < fill_reg);
    assign found    = pend_reg && (rd_data_reg == key_reg);
    assign out_load = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        hash_next       = hash_reg;
        recent_next     = recent_reg;
        kw_next         = kw_reg;
        sat_next        = sat_reg;
        fill_next       = fill_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        key_next        = key_reg;
        name_kw_next    = name_kw_reg;
        res_status_next = res_status_reg;
        res_hit_next    = res_hit_reg;
        wr_en           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (byte_valid)
                    begin
                        hash_next   = hash_upd;
                        recent_next = {recent_reg[ndkf_pkg::HIST_LEN-2:0], lc};
                        kw_next     = byte_kw;
                    end
                    if (last_byte)
                    begin
                        key_next     = final_hash;
                        name_kw_next = byte_kw;
                        hash_next    = ndkf_pkg::FNV_BASIS;
                        recent_next  = '0;
                        kw_next      = 1'b0;
                        idx_next     = '0;
                        pend_next    = 1'b0;
                        if (sat_reg)
                        begin
                            res_status_next = ndkf_pkg::ST_SKIP;
                            res_hit_next    = 1'b0;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                // one table read per cycle, compared in the next cycle
                pend_next = rd_en;
                if (rd_en)
                begin
                    idx_next = idx_reg + ndkf_pkg::CNT_W'(1);
                end
                if (found)
                begin
                    res_status_next = ndkf_pkg::ST_SEEN;
                    res_hit_next    = 1'b0;
                    state_next      = S_FINISH;
                end
                else if (!pend_reg && !rd_en)
                begin
                    if (fill_reg == ndkf_pkg::CNT_W'(ndkf_pkg::TABLE_DEPTH))
                    begin
                        sat_next        = 1'b1;
                        res_status_next = ndkf_pkg::ST_SKIP;
                        res_hit_next    = 1'b0;
                    end
                    else
                    begin
                        wr_en           = 1'b1;
                        fill_next       = fill_reg + ndkf_pkg::CNT_W'(1);
                        res_status_next = ndkf_pkg::ST_NEW;
                        res_hit_next    = name_kw_reg;
                    end
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_hit_next    = out_hit_reg;
        out_hash_next   = out_hash_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_hit_next    = res_hit_reg;
            out_hash_next   = key_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hash_reg      <= ndkf_pkg::FNV_BASIS;
            recent_reg    <= '0;
            kw_reg        <= 1'b0;
            sat_reg       <= 1'b0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            recent_reg    <= recent_next;
            kw_reg        <= kw_next;
            sat_reg       <= sat_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        name_kw_reg    <= name_kw_next;
        res_status_reg <= res_status_next;
        res_hit_reg    <= res_hit_next;
        out_status_reg <= out_status_next;
        out_hit_reg    <= out_hit_next;
        out_hash_reg   <= out_hash_next;
    end

    // seen table: entries below the fill count are live
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            seen_mem[fill_reg[ndkf_pkg::ADDR_W-1:0]] <= key_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= seen_mem[idx_reg[ndkf_pkg::ADDR_W-1:0]];
        end
    end

endmodule
